### src/dual_motor_incremental_pi_top_macros.svh
// Assertion helpers used by the checker of this block.
`ifndef DUAL_MOTOR_INCREMENTAL_PI_TOP_MACROS_SVH
`define DUAL_MOTOR_INCREMENTAL_PI_TOP_MACROS_SVH

// Clocked assertion, muted while reset is held.
`define DMIP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define DMIP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### src/dmip_pkg.sv
`default_nettype none
package dmip_pkg;

    localparam int DUTY_MAX  = 10000;
    localparam int HALF_DUTY = 5000;

    localparam logic [15:0] PROP_GAIN_RST     = 16'd0;
    localparam logic [15:0] INTEGRAL_GAIN_RST = 16'd1280;
    localparam logic [14:0] OUTPUT_LIMIT_RST  = 15'd11500;

    typedef enum logic [1:0] {
        REG_PROP_GAIN     = 2'd0,
        REG_INTEGRAL_GAIN = 2'd1,
        REG_OUTPUT_LIMIT  = 2'd2
    } cfg_reg_t;

    // Drive clamped to +/- DUTY_MAX, then halved toward zero.
    function automatic logic signed [17:0] drive_half(input logic signed [15:0] drive);
        logic signed [17:0] lim;
        logic signed [17:0] d;
        lim = 18'(DUTY_MAX);
        d   = 18'(drive);
        if (d > lim) begin
            d = lim;
        end else if (d < -lim) begin
            d = -lim;
        end
        return (d + $signed({17'd0, d < 0})) >>> 1;
    endfunction

    function automatic logic [13:0] duty_a(input logic signed [15:0] drive);
        logic signed [18:0] t;
        t = 19'(HALF_DUTY) - 19'(drive_half(drive));
        return t[13:0];
    endfunction

    function automatic logic [13:0] duty_b(input logic signed [15:0] drive);
        logic signed [18:0] t;
        t = 19'(HALF_DUTY) + 19'(drive_half(drive));
        return t[13:0];
    endfunction

endpackage
`default_nettype wire

### src/dual_motor_incremental_pi_top.sv
// Two-lane incremental PI speed controller with complementary H-bridge duties.
// Each accepted item (targets and encoder counts for both motors, the right
// count taken as mirrored) yields one result: the clamped PI output of each
// motor and its two leg duties. The block takes one item every clock cycle
// while the result is not stalled; an item lands in the input register, and
// the PI step (two multiplies per lane, the Q8.8 scale with truncation toward
// zero and the output clamp) is combinational between that register and the
// result register. Each lane's error and output are updated as the item
// enters the result register, so the next item steps on from them as soon as
// it advances. Gains and the output limit are to be written through the cfg_
// port by the user only while no item is in flight; the block does not enforce
// it. Reset restores kp 0, ki 5.0 and limit 11500 and clears both lanes.
`default_nettype none
module dual_motor_incremental_pi_top
    import dmip_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_wr_data,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic signed [15:0] s_left_target,
    input  wire logic signed [15:0] s_right_target,
    input  wire logic signed [15:0] s_left_count,
    input  wire logic signed [15:0] s_right_count,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_left_drive,
    output logic signed [15:0]      m_right_drive,
    output logic [13:0]             m_left_duty_a,
    output logic [13:0]             m_left_duty_b,
    output logic [13:0]             m_right_duty_a,
    output logic [13:0]             m_right_duty_b
);

    // configuration
    logic [15:0] prop_gain_reg, prop_gain_next;
    logic [15:0] integral_gain_reg, integral_gain_next;
    logic [14:0] output_limit_reg, output_limit_next;

    // input stage
    logic               in_valid_reg, in_valid_next;
    logic signed [15:0] in_target_reg [2];
    logic signed [15:0] in_target_next [2];
    logic signed [15:0] in_count_reg [2];
    logic signed [15:0] in_count_next [2];

    // result stage; the drive registers double as each lane's last output
    logic               out_valid_reg, out_valid_next;
    logic signed [15:0] drive_reg [2];
    logic signed [15:0] drive_next [2];
    logic signed [17:0] last_err_reg [2];
    logic signed [17:0] last_err_next [2];

    logic accept_in;
    logic advance;

    logic signed [17:0] err [2];
    logic signed [17:0] derr [2];
    logic signed [34:0] prod_p [2];
    logic signed [34:0] prod_i [2];
    logic signed [35:0] sum [2];
    logic signed [27:0] delta [2];
    logic signed [28:0] raw_out [2];
    logic signed [28:0] lim;
    logic signed [15:0] new_out [2];

    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign accept_in = s_valid && s_ready;

    always_comb begin
        prop_gain_next     = prop_gain_reg;
        integral_gain_next = integral_gain_reg;
        output_limit_next  = output_limit_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_PROP_GAIN:     prop_gain_next     = cfg_wr_data;
                REG_INTEGRAL_GAIN: integral_gain_next = cfg_wr_data;
                REG_OUTPUT_LIMIT:  output_limit_next  = cfg_wr_data[14:0];
                default: ;
            endcase
        end
    end

    // PI step per lane
    always_comb begin
        lim = $signed({14'd0, output_limit_reg});
        // right encoder is mirrored: error = target + raw count
        err[0] = 18'(in_target_reg[0]) - 18'(in_count_reg[0]);
        err[1] = 18'(in_target_reg[1]) + 18'(in_count_reg[1]);
        for (int i = 0; i < 2; i++) begin
            derr[i]   = err[i] - last_err_reg[i];
            prod_p[i] = $signed({1'b0, prop_gain_reg}) * derr[i];
            prod_i[i] = $signed({1'b0, integral_gain_reg}) * err[i];
            sum[i]    = 36'(prod_p[i]) + 36'(prod_i[i]);
            // divide by 256, truncating toward zero
            delta[i]  = 28'(sum[i] >>> 8)
                      + 28'(sum[i][35] && (sum[i][7:0] != 8'd0));
            raw_out[i] = 29'(drive_reg[i]) + 29'(delta[i]);
            if (raw_out[i] > lim) begin
                new_out[i] = lim[15:0];
            end else if (raw_out[i] < -lim) begin
                new_out[i] = 16'(-lim);
            end else begin
                new_out[i] = raw_out[i][15:0];
            end
        end
    end

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        in_target_next = in_target_reg;
        in_count_next  = in_count_reg;
        drive_next     = drive_reg;
        last_err_next  = last_err_reg;
        if (advance) begin
            in_valid_next = 1'b0;
            out_valid_next = 1'b1;
            drive_next    = new_out;
            last_err_next = err;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (accept_in) begin
            in_valid_next    = 1'b1;
            in_target_next[0] = s_left_target;
            in_target_next[1] = s_right_target;
            in_count_next[0]  = s_left_count;
            in_count_next[1]  = s_right_count;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg     <= PROP_GAIN_RST;
            integral_gain_reg <= INTEGRAL_GAIN_RST;
            output_limit_reg  <= OUTPUT_LIMIT_RST;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            drive_reg[0]      <= '0;
            drive_reg[1]      <= '0;
            last_err_reg[0]   <= '0;
            last_err_reg[1]   <= '0;
        end else begin
            prop_gain_reg     <= prop_gain_next;
            integral_gain_reg <= integral_gain_next;
            output_limit_reg  <= output_limit_next;
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            drive_reg         <= drive_next;
            last_err_reg      <= last_err_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_target_reg <= in_target_next;
        in_count_reg  <= in_count_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_left_drive   = drive_reg[0];
    assign m_right_drive  = drive_reg[1];
    assign m_left_duty_a  = duty_a(drive_reg[0]);
    assign m_left_duty_b  = duty_b(drive_reg[0]);
    assign m_right_duty_a = duty_a(drive_reg[1]);
    assign m_right_duty_b = duty_b(drive_reg[1]);

endmodule
`default_nettype wire

### src/dmip_checker.sv
`default_nettype none
`include "dual_motor_incremental_pi_top_macros.svh"
module dmip_checker
    import dmip_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               cfg_wr_en,
    input wire logic [1:0]         cfg_index,
    input wire logic [15:0]        cfg_wr_data,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic signed [15:0] s_left_target,
    input wire logic signed [15:0] s_right_target,
    input wire logic signed [15:0] s_left_count,
    input wire logic signed [15:0] s_right_count,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_left_drive,
    input wire logic signed [15:0] m_right_drive,
    input wire logic [13:0]        m_left_duty_a,
    input wire logic [13:0]        m_left_duty_b,
    input wire logic [13:0]        m_right_duty_a,
    input wire logic [13:0]        m_right_duty_b
);

    logic [13:0] left_leg_sum;
    logic [13:0] right_leg_sum;
    logic        cfg_seen;

    assign left_leg_sum  = m_left_duty_a + m_left_duty_b;
    assign right_leg_sum = m_right_duty_a + m_right_duty_b;
    assign cfg_seen      = cfg_wr_en && (cfg_index != 2'd3) && (cfg_wr_data != 16'hffff);

    `DMIP_ASSERT(a_out_holds, m_valid && !m_ready |=> m_valid, "result dropped while stalled")

    `DMIP_ASSERT(a_legs_complement, m_valid |-> (left_leg_sum == 14'(2 * HALF_DUTY)) && (right_leg_sum == 14'(2 * HALF_DUTY)), "leg duties not complementary")

    `DMIP_ASSERT(a_result_needs_item, $rose(m_valid) |-> $past(s_valid && s_ready, 2), "result without an accepted item")

    `DMIP_ASSERT(a_zero_drive_mid, m_valid && (m_left_drive == 16'sd0) |-> (m_left_duty_a == 14'(HALF_DUTY)) || cfg_seen, "zero drive not at half duty")

endmodule

bind dual_motor_incremental_pi_top dmip_checker u_dmip_checker (.*);
`default_nettype wire

### dv/dual_motor_incremental_pi_top_tb.sv
`default_nettype none
module dual_motor_incremental_pi_top_tb;
    import dmip_pkg::*;

    localparam logic [1:0] REG_SPARE = 2'd3;   // not a register; writes must be ignored
    localparam int HOLD_CYCLES = 200;
    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef struct {
        logic signed [15:0] left_drive;
        logic signed [15:0] right_drive;
        logic [13:0]        left_duty_a;
        logic [13:0]        left_duty_b;
        logic [13:0]        right_duty_a;
        logic [13:0]        right_duty_b;
    } drive_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_index = REG_PROP_GAIN;
    logic [15:0] cfg_wr_data = '0;

    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_left_target = '0;
    logic signed [15:0] s_right_target = '0;
    logic signed [15:0] s_left_count = '0;
    logic signed [15:0] s_right_count = '0;

    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_left_drive;
    logic signed [15:0] m_right_drive;
    logic [13:0]        m_left_duty_a;
    logic [13:0]        m_left_duty_b;
    logic [13:0]        m_right_duty_a;
    logic [13:0]        m_right_duty_b;

    // predictor copy of the registers and lane state
    logic [15:0]        kp_q88 = PROP_GAIN_RST;
    logic [15:0]        ki_q88 = INTEGRAL_GAIN_RST;
    logic [14:0]        drive_limit = OUTPUT_LIMIT_RST;
    logic signed [17:0] err_left = '0;
    logic signed [17:0] err_right = '0;
    logic signed [15:0] out_left = '0;
    logic signed [15:0] out_right = '0;

    drive_result_t drive_q[$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;
    bit            steady = 1'b0;       // no idling on either side
    bit            hold_req = 1'b0;
    bit            hold_served = 1'b0;
    int            hold_left = 0;

    dual_motor_incremental_pi_top DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_left_target  (s_left_target),
        .s_right_target (s_right_target),
        .s_left_count   (s_left_count),
        .s_right_count  (s_right_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_drive   (m_left_drive),
        .m_right_drive  (m_right_drive),
        .m_left_duty_a  (m_left_duty_a),
        .m_left_duty_b  (m_left_duty_b),
        .m_right_duty_a (m_right_duty_a),
        .m_right_duty_b (m_right_duty_b)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // incremental PI step: new clamped output from the error and last state
    function automatic logic signed [15:0] pi_next(input logic signed [17:0] e,
                                                   input logic signed [17:0] e_prev,
                                                   input logic signed [15:0] o_prev);
        longint acc;
        longint o;
        longint lim;
        acc = longint'(kp_q88) * (longint'(e) - longint'(e_prev))
            + longint'(ki_q88) * longint'(e);
        o = longint'(o_prev) + acc / 256;
        lim = longint'(drive_limit);
        if (o > lim) begin
            o = lim;
        end else if (o < -lim) begin
            o = -lim;
        end
        return 16'(o);
    endfunction

    function automatic logic [13:0] leg_duty(input logic signed [15:0] drive, input bit leg_b);
        longint d;
        longint half;
        d = longint'(drive);
        if (d > DUTY_MAX) begin
            d = DUTY_MAX;
        end else if (d < -DUTY_MAX) begin
            d = -DUTY_MAX;
        end
        half = d / 2;
        return 14'(leg_b ? HALF_DUTY + half : HALF_DUTY - half);
    endfunction

    task automatic predict_drives(input logic signed [15:0] lt, input logic signed [15:0] rt,
                                  input logic signed [15:0] lc, input logic signed [15:0] rc);
        logic signed [17:0] e_l;
        logic signed [17:0] e_r;
        drive_result_t r;
        e_l = 18'(longint'(lt) - longint'(lc));
        e_r = 18'(longint'(rt) + longint'(rc));   // right encoder is mirrored
        r.left_drive  = pi_next(e_l, err_left, out_left);
        r.right_drive = pi_next(e_r, err_right, out_right);
        err_left  = e_l;
        err_right = e_r;
        out_left  = r.left_drive;
        out_right = r.right_drive;
        r.left_duty_a  = leg_duty(r.left_drive, 1'b0);
        r.left_duty_b  = leg_duty(r.left_drive, 1'b1);
        r.right_duty_a = leg_duty(r.right_drive, 1'b0);
        r.right_duty_b = leg_duty(r.right_drive, 1'b1);
        drive_q.push_back(r);
    endtask

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint wanted);
        if (got != wanted) begin
            report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, wanted));
        end
    endtask

    // Called at a rising edge; returns at the edge where the item is taken.
    task automatic send_tick(input logic signed [15:0] lt, input logic signed [15:0] rt,
                             input logic signed [15:0] lc, input logic signed [15:0] rc);
        logic took;
        while (!steady && $urandom_range(99) < 32) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_left_target  <= lt;
        s_right_target <= rt;
        s_left_count   <= lc;
        s_right_count  <= rc;
        took = 1'b0;
        while (!took) begin
            @(posedge aclk);
            took = s_ready;
        end
        predict_drives(lt, rt, lc, rc);
    endtask

    // drop valid and wait for the block to drain
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (drive_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        case (idx)
            REG_PROP_GAIN:     kp_q88 = val;
            REG_INTEGRAL_GAIN: ki_q88 = val;
            REG_OUTPUT_LIMIT:  drive_limit = val[14:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input logic [15:0] kp, input logic [15:0] ki,
                                input logic [15:0] lim);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEGRAL_GAIN, ki);
        write_reg(REG_OUTPUT_LIMIT, lim);
        write_reg(REG_SPARE, 16'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic random_tick();
        logic signed [15:0] lt;
        logic signed [15:0] rt;
        logic signed [15:0] lc;
        logic signed [15:0] rc;
        if ($urandom_range(9) < 2) begin
            lt = 16'($urandom);
            rt = 16'($urandom);
            lc = 16'($urandom);
            rc = 16'($urandom);
        end else begin
            // plausible speeds with encoder counts close to target
            lt = 16'(int'($urandom_range(800)) - 400);
            rt = 16'(int'($urandom_range(800)) - 400);
            lc = 16'(int'(lt) + int'($urandom_range(60)) - 30);
            rc = 16'(-int'(rt) + int'($urandom_range(60)) - 30);
        end
        send_tick(lt, rt, lc, rc);
    endtask

    task automatic test_reset_defaults();
        send_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_tick(16'sd32767, -16'sd32768, -16'sd32768, -16'sd32768);
        send_tick(-16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767);
        send_tick(16'sd100, 16'sd100, 16'sd100, -16'sd100);
        send_tick(16'sd1, -16'sd1, 16'sd0, 16'sd0);
        settle();
    endtask

    task automatic test_config_extremes();
        // full gains: drives pass the duty clamp
        apply_config(16'hFFFF, 16'hFFFF, 16'd32767);
        send_tick(16'sd32767, 16'sd32767, 16'sd0, 16'sd0);
        send_tick(-16'sd32768, -16'sd32768, 16'sd32767, -16'sd32767);
        send_tick(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        settle();
        // zero limit pins both drives
        apply_config(16'd0, 16'd0, 16'd0);
        send_tick(16'sd1234, -16'sd999, -16'sd5, 16'sd7);
        send_tick(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        settle();
        // tiny gains: negative sums truncate toward zero; limit top bit dropped
        apply_config(16'd1, 16'd1, 16'hFFFF);
        send_tick(-16'sd1, 16'sd0, 16'sd0, 16'sd0);
        send_tick(16'sd0, -16'sd255, 16'sd0, 16'sd0);
        send_tick(16'sd300, -16'sd300, 16'sd0, 16'sd0);
        settle();
        // drive of one halves to zero
        apply_config(16'd256, 16'd0, 16'd1);
        send_tick(16'sd5, -16'sd5, 16'sd0, 16'sd0);
        send_tick(-16'sd5, 16'sd5, 16'sd0, 16'sd0);
        settle();
        // odd drives just above the duty maximum
        apply_config(16'd0, 16'd256, 16'd10001);
        send_tick(16'sd10001, -16'sd10001, 16'sd0, 16'sd0);
        send_tick(16'sd3, -16'sd3, 16'sd0, 16'sd0);
        settle();
        apply_config(16'hFFFF, 16'd0, 16'd32767);
        send_tick(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
        send_tick(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        settle();
    endtask

    task automatic test_backpressure();
        apply_config(16'd512, 16'd128, 16'd11500);
        hold_req = 1'b1;    // receiver stalls while items keep coming
        repeat (40) random_tick();
        settle();
    endtask

    task automatic test_random_ticks();
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] lim;
        for (int phase = 0; phase < 8; phase++) begin
            kp  = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'd0)
                                           : 16'($urandom_range(1536));
            ki  = ($urandom_range(3) == 0) ? ($urandom_range(1) ? 16'hFFFF : 16'd0)
                                           : 16'($urandom_range(1536));
            lim = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(20000));
            apply_config(kp, ki, lim);
            steady = (phase == 3);
            repeat (200) random_tick();
            settle();
        end
        steady = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (hold_req && !hold_served) begin
            hold_served <= 1'b1;
            hold_left   <= HOLD_CYCLES;
            m_ready     <= 1'b0;
        end else begin
            m_ready <= steady || ($urandom_range(99) >= 32);
        end
    end

    always @(posedge aclk) begin
        drive_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (drive_q.size() == 0) begin
                report_mismatch($sformatf("result with no item pending: drives %0d %0d",
                                          m_left_drive, m_right_drive));
            end else begin
                want = drive_q.pop_front();
                check_field("left_drive", m_left_drive, want.left_drive);
                check_field("right_drive", m_right_drive, want.right_drive);
                check_field("left_duty_a", m_left_duty_a, want.left_duty_a);
                check_field("left_duty_b", m_left_duty_b, want.left_duty_b);
                check_field("right_duty_a", m_right_duty_a, want.right_duty_a);
                check_field("right_duty_b", m_right_duty_b, want.right_duty_b);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_config_extremes();
        test_backpressure();
        test_random_ticks();
        settle();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
`default_nettype wire
